[hdl/ifbs_pkg.sv]
`timescale 1ns / 1ps

package ifbs_pkg;

    // framing and escape bytes
    localparam logic [7:0] FRAME_FLAG = 8'h7E;
    localparam logic [7:0] ESC_BYTE   = 8'h7D;
    localparam logic [7:0] ESC_XOR    = 8'h20;
    localparam logic [7:0] CTRL_SEQ0  = 8'h00;
    localparam logic [7:0] CTRL_SEQ1  = 8'h02;
    localparam logic [7:0] ADDR_RESET = 8'h03;

    // register map
    localparam int        PADDR_W      = 3;
    localparam logic      REG_ADDRESS  = 1'b0;

    // one request as classified by the front part
    typedef struct packed {
        logic       hdr;
        logic [7:0] addr;
        logic [7:0] ctrl;
        logic [7:0] data;
        logic       esc;
        logic       last;
        logic [7:0] bcc2;
    } job_t;

    // output byte positions within a request
    typedef enum logic [2:0] {
        SLOT_FLAG_OPEN,
        SLOT_ADDR,
        SLOT_CTRL,
        SLOT_BCC1,
        SLOT_DATA,
        SLOT_ESC,
        SLOT_BCC2,
        SLOT_FLAG_CLOSE
    } slot_t;

endpackage

[hdl/ifbs_front.sv]
`timescale 1ns / 1ps

module ifbs_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] payload_byte
    input  logic              s_tuser,   // [0] seq_bit
    input  logic              s_tlast,   // last_byte
    input  logic [7:0]        address_byte,
    input  logic              q_full,
    output logic              q_push,
    output ifbs_pkg::job_t    q_job
);

    logic       in_frame_reg, in_frame_next;
    logic [7:0] parity_reg, parity_next;
    logic [7:0] ctrl;
    logic [7:0] parity_sum;

    // accept whenever the queue has room
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // classify the request
    always_comb begin
        ctrl       = s_tuser ? ifbs_pkg::CTRL_SEQ1 : ifbs_pkg::CTRL_SEQ0;
        parity_sum = (in_frame_reg ? parity_reg : 8'h00) ^ s_tdata;
        q_job.hdr  = !in_frame_reg;
        q_job.addr = address_byte;
        q_job.ctrl = ctrl;
        q_job.data = s_tdata;
        q_job.esc  = (s_tdata == ifbs_pkg::FRAME_FLAG) || (s_tdata == ifbs_pkg::ESC_BYTE);
        q_job.last = s_tlast;
        q_job.bcc2 = parity_sum;
    end

    // frame state and running parity
    always_comb begin
        in_frame_next = in_frame_reg;
        parity_next   = parity_reg;
        if (q_push) begin
            in_frame_next = !s_tlast;
            parity_next   = s_tlast ? 8'h00 : parity_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            parity_reg   <= 8'h00;
        end else begin
            in_frame_reg <= in_frame_next;
            parity_reg   <= parity_next;
        end
    end

endmodule

[hdl/ifbs_queue.sv]
`timescale 1ns / 1ps

module ifbs_queue #(
    parameter int DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  ifbs_pkg::job_t    push_job,
    output logic              full,
    input  logic              pop,
    output ifbs_pkg::job_t    head_job,
    output logic              empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ifbs_pkg::job_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[hdl/ifbs_back.sv]
`timescale 1ns / 1ps

module ifbs_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  ifbs_pkg::job_t    head_job,
    input  logic              q_empty,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [7:0] out_byte
    output logic              m_tuser,   // [0] frame_end
    output logic              m_tlast    // run_end
);

    ifbs_pkg::slot_t slot_reg, slot_next, cur_slot, step_slot;
    logic       busy_reg, busy_next;
    logic       valid_reg, valid_next;
    logic [7:0] data_reg, data_next;
    logic       last_reg, last_next;
    logic       user_reg, user_next;
    logic [7:0] byte_sel;
    logic       done;
    logic       fire;

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

    // sequencer over the byte positions of the head request
    always_comb begin
        if (busy_reg) begin
            cur_slot = slot_reg;
        end else begin
            cur_slot = head_job.hdr ? ifbs_pkg::SLOT_FLAG_OPEN : ifbs_pkg::SLOT_DATA;
        end

        fire = !q_empty && (!valid_reg || m_tready);

        unique case (cur_slot)
            ifbs_pkg::SLOT_FLAG_OPEN: begin
                byte_sel  = ifbs_pkg::FRAME_FLAG;
                step_slot = ifbs_pkg::SLOT_ADDR;
                done      = 1'b0;
            end
            ifbs_pkg::SLOT_ADDR: begin
                byte_sel  = head_job.addr;
                step_slot = ifbs_pkg::SLOT_CTRL;
                done      = 1'b0;
            end
            ifbs_pkg::SLOT_CTRL: begin
                byte_sel  = head_job.ctrl;
                step_slot = ifbs_pkg::SLOT_BCC1;
                done      = 1'b0;
            end
            ifbs_pkg::SLOT_BCC1: begin
                byte_sel  = head_job.addr ^ head_job.ctrl;
                step_slot = ifbs_pkg::SLOT_DATA;
                done      = 1'b0;
            end
            ifbs_pkg::SLOT_DATA: begin
                byte_sel  = head_job.esc ? ifbs_pkg::ESC_BYTE : head_job.data;
                step_slot = head_job.esc ? ifbs_pkg::SLOT_ESC : ifbs_pkg::SLOT_BCC2;
                done      = !head_job.esc && !head_job.last;
            end
            ifbs_pkg::SLOT_ESC: begin
                // flag maps to 0x5e, escape to 0x5d
                byte_sel  = head_job.data ^ ifbs_pkg::ESC_XOR;
                step_slot = ifbs_pkg::SLOT_BCC2;
                done      = !head_job.last;
            end
            ifbs_pkg::SLOT_BCC2: begin
                byte_sel  = head_job.bcc2;
                step_slot = ifbs_pkg::SLOT_FLAG_CLOSE;
                done      = 1'b0;
            end
            ifbs_pkg::SLOT_FLAG_CLOSE: begin
                byte_sel  = ifbs_pkg::FRAME_FLAG;
                step_slot = ifbs_pkg::SLOT_FLAG_OPEN;
                done      = 1'b1;
            end
            default: begin
                byte_sel  = ifbs_pkg::FRAME_FLAG;
                step_slot = ifbs_pkg::SLOT_FLAG_OPEN;
                done      = 1'b1;
            end
        endcase

        q_pop      = fire && done;
        busy_next  = busy_reg;
        slot_next  = slot_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        user_next  = user_reg;

        if (fire) begin
            busy_next  = !done;
            slot_next  = step_slot;
            valid_next = 1'b1;
            data_next  = byte_sel;
            last_next  = done;
            user_next  = (cur_slot == ifbs_pkg::SLOT_FLAG_CLOSE);
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            slot_reg  <= ifbs_pkg::SLOT_FLAG_OPEN;
            valid_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            slot_reg  <= slot_next;
            valid_reg <= valid_next;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        last_reg <= last_next;
        user_reg <= user_next;
    end

endmodule

[hdl/info_frame_byte_stuffer.sv]
`timescale 1ns / 1ps
// Information frame byte stuffer.
// Input stream: one payload byte per request on s_tdata, the frame's sequence
// bit on s_tuser (sampled only on the first byte of a frame) and s_tlast on
// the final payload byte. Output stream: one framed byte per request on
// m_tdata, m_tlast on the last byte caused by an input request, m_tuser on
// the closing flag of a frame.
// The first byte of a frame is preceded by flag, address, control and BCC1.
// Payload flag and escape bytes are sent as two-byte escape sequences. The
// last byte is followed by BCC2 (unstuffed XOR of the payload) and a flag.
// A front stage classifies each request into a four-entry queue; a back
// sequencer emits one byte per cycle into an output register unless the
// queue is empty or the output is stalled. An input yields 1 or 2 output
// bytes mid-frame, plus 4 for a header and 2 for a trailer. An accepted
// input is written into the queue, then the back sequencer loads its first
// byte into the output register. When m_tready is low the output register
// holds and the queue keeps accepting until it is full, then s_tready drops.
// Reset clears the frame state, queue and output valid; address_byte
// (APB byte address 0) returns to 0x03.

module info_frame_byte_stuffer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] payload_byte
    input  logic                          s_tuser,   // [0] seq_bit
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] out_byte
    output logic                          m_tuser,   // [0] frame_end
    output logic                          m_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ifbs_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [7:0]     addr_reg, addr_next;
    logic           reg_sel;
    logic           q_full, q_push, q_pop, q_empty;
    ifbs_pkg::job_t push_job, head_job;

    // register file
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == ifbs_pkg::REG_ADDRESS);
    assign prdata  = reg_sel ? {24'h000000, addr_reg} : 32'h00000000;

    always_comb begin
        addr_next = addr_reg;
        if (psel && penable && pwrite && pready && reg_sel) begin
            addr_next = pwdata[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg <= ifbs_pkg::ADDR_RESET;
        end else begin
            addr_reg <= addr_next;
        end
    end

    ifbs_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .address_byte (addr_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_job        (push_job)
    );

    ifbs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty)
    );

    ifbs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[hdl/ifbs_checker.sv]
`timescale 1ns / 1ps

module ifbs_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       m_tuser,
    input  logic       m_tlast
);

    // stalled output request holds its byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output byte changed");

    // closing flag always ends the run of its input
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end without run end");

    // frame end marks a flag byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == ifbs_pkg::FRAME_FLAG)
        else $error("frame end on a non-flag byte");

    // nothing offered straight after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind info_frame_byte_stuffer ifbs_checker u_ifbs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
